/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the gauge needle block. Each one checks at the
// rising edge of clk and is switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent and consequent in the same cycle
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the cycle after the antecedent
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/gnf_pkg.sv */
// ----------------------------------------------------------------------------
// gnf_pkg
// Shared widths, constants, register codes and controller-to-datapath
// command types of the gauge needle filter and angle map.
// ----------------------------------------------------------------------------
`default_nettype none

package gnf_pkg;

    localparam int NUM_GAUGES_DEF = 4;
    localparam int NUM_RANGES     = 4;

    localparam int IDX_W     = 2;
    localparam int SAMPLE_W  = 16;
    localparam int ANGLE_W   = 16;
    localparam int COEF_W    = 8;
    localparam int FRAC_W    = 8;
    localparam int FV_W      = SAMPLE_W + FRAC_W;
    localparam int ACC_W     = FV_W + COEF_W;
    localparam int DEG_W     = 9;
    localparam int NUM_W     = FV_W + DEG_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 50;

    // degrees to Q3.13 radians: deg * RAD_NUM / RAD_DEN
    localparam int RAD_NUM_W = 29;
    localparam int RAD_DEN_W = 22;
    localparam logic [RAD_NUM_W-1:0] RAD_NUM = 29'd502654816;
    localparam logic [RAD_DEN_W-1:0] RAD_DEN = 22'd3515625;

    localparam int MUL_A_W = FV_W;
    localparam int MUL_B_W = RAD_NUM_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int NUM_LO_W = 17;
    localparam int NUM_HI_W = NUM_W - NUM_LO_W;
    localparam int QUO_W    = ANGLE_W + 1;
    localparam int DIVD_W   = NUM_W + RAD_NUM_W;
    localparam int DIVS_W   = FV_W + RAD_DEN_W;

    localparam int FDIV_BITS  = 2;
    localparam int FDIV_STEPS = FV_W / FDIV_BITS;
    localparam int ADIV_STEPS = QUO_W;
    localparam int CNT_W      = 5;

    localparam logic [COEF_W-1:0] TIME_CONST_RESET = 8'd10;
    localparam logic [COEF_W-1:0] LAG_WEIGHT_RESET = 8'd8;

    typedef struct packed {
        logic [DEG_W-1:0]    deg_end;
        logic [DEG_W-1:0]    deg_start;
        logic [SAMPLE_W-1:0] val_top;
        logic [SAMPLE_W-1:0] val_base;
    } range_t;

    localparam range_t RANGE_RESET [NUM_RANGES] = '{
        range_t'(50'd199071898009600),
        range_t'(50'd436570540670976),
        range_t'(50'd436570540670976),
        range_t'(50'd199072029081600)
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIME_CONST = 3'd0,
        REG_LAG_WEIGHT = 3'd1,
        REG_RANGE0     = 3'd2,
        REG_RANGE1     = 3'd3,
        REG_RANGE2     = 3'd4,
        REG_RANGE3     = 3'd5
    } cfg_reg_t;

    typedef enum logic [3:0] {
        OP_NONE  = 4'd0,
        OP_MUL_A = 4'd1,
        OP_MUL_B = 4'd2,
        OP_FDIV  = 4'd3,
        OP_PREP  = 4'd4,
        OP_MUL_C = 4'd5,
        OP_MUL_D = 4'd6,
        OP_MUL_E = 4'd7,
        OP_MUL_F = 4'd8,
        OP_MUL_G = 4'd9,
        OP_ADIV  = 4'd10
    } dp_op_t;

    typedef struct packed {
        logic   in_load;
        dp_op_t op;
        logic   out_load;
    } dp_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/gnf_ctrl.sv */
// ----------------------------------------------------------------------------
// gnf_ctrl
// Sequencer for one item: filter multiplies, filter divide, range prep,
// angle multiplies, angle divide, then hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gnf_ctrl
    import gnf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  wire logic out_stall,
    output dp_cmd_t   cmd
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_MUL_A = 12'b0000_0000_0010,
        S_MUL_B = 12'b0000_0000_0100,
        S_FDIV  = 12'b0000_0000_1000,
        S_PREP  = 12'b0000_0001_0000,
        S_MUL_C = 12'b0000_0010_0000,
        S_MUL_D = 12'b0000_0100_0000,
        S_MUL_E = 12'b0000_1000_0000,
        S_MUL_F = 12'b0001_0000_0000,
        S_MUL_G = 12'b0010_0000_0000,
        S_ADIV  = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd.in_load  = 1'b0;
        cmd.op       = OP_NONE;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    state_next  = S_MUL_A;
                end
            end
            S_MUL_A:
            begin
                cmd.op     = OP_MUL_A;
                state_next = S_MUL_B;
            end
            S_MUL_B:
            begin
                cmd.op     = OP_MUL_B;
                cnt_next   = CNT_W'(FDIV_STEPS - 1);
                state_next = S_FDIV;
            end
            S_FDIV:
            begin
                cmd.op = OP_FDIV;
                if (cnt_reg == '0)
                    state_next = S_PREP;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            S_PREP:
            begin
                cmd.op     = OP_PREP;
                state_next = S_MUL_C;
            end
            S_MUL_C:
            begin
                cmd.op     = OP_MUL_C;
                state_next = S_MUL_D;
            end
            S_MUL_D:
            begin
                cmd.op     = OP_MUL_D;
                state_next = S_MUL_E;
            end
            S_MUL_E:
            begin
                cmd.op     = OP_MUL_E;
                state_next = S_MUL_F;
            end
            S_MUL_F:
            begin
                cmd.op     = OP_MUL_F;
                state_next = S_MUL_G;
            end
            S_MUL_G:
            begin
                cmd.op     = OP_MUL_G;
                cnt_next   = CNT_W'(ADIV_STEPS - 1);
                state_next = S_ADIV;
            end
            S_ADIV:
            begin
                cmd.op = OP_ADIV;
                if (cnt_reg == '0)
                    state_next = S_DONE;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            S_DONE:
            begin
                // output register free, or emptied at this edge
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.out_load | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* rtl/core/gnf_dp.sv */
// ----------------------------------------------------------------------------
// gnf_dp
// Datapath: per-gauge filter state, one shared 24x29 multiplier, a
// two-bit-per-cycle filter divider, a one-bit-per-cycle angle divider and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gnf_dp
    import gnf_pkg::*;
#(
    parameter int NUM_GAUGES = NUM_GAUGES_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dp_cmd_t             cmd,
    input  wire logic [COEF_W-1:0]   time_const,
    input  wire logic [COEF_W-1:0]   lag_weight,
    input  wire range_t              gauge_range [NUM_RANGES],
    input  wire logic [IDX_W-1:0]    gauge_index,
    input  wire logic [SAMPLE_W-1:0] sample,
    output logic [IDX_W-1:0]         gauge_id,
    output logic [ANGLE_W-1:0]       needle_angle
);

    localparam int GIDX_W = (NUM_GAUGES > 1) ? $clog2(NUM_GAUGES) : 1;

    logic [FV_W-1:0]     fv_reg [NUM_GAUGES];

    logic [IDX_W-1:0]    idx_reg;
    logic                ok_reg;
    logic [GIDX_W-1:0]   sel_reg;
    logic [SAMPLE_W-1:0] x_reg;
    logic [COEF_W-1:0]   t_reg;
    logic [COEF_W-1:0]   w_reg;
    logic [FV_W-1:0]     yprev_reg;
    range_t              rng_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [COEF_W-1:0]   frem_reg;
    logic [FV_W-1:0]     fq_reg;
    logic [FV_W-1:0]     d_reg;
    logic [FV_W-1:0]     toff_reg;
    logic [NUM_W-1:0]    n_reg;
    logic [DIVD_W-1:0]   a_reg;
    logic [DIVS_W-1:0]   b_reg;
    logic [DIVS_W-1:0]   arem_reg;
    logic [QUO_W-1:0]    aq_reg;
    logic [IDX_W-1:0]    gauge_id_reg;
    logic [ANGLE_W-1:0]  angle_reg;

    logic [COEF_W-1:0]   t_eff;
    logic [COEF_W-1:0]   w_eff;
    logic [GIDX_W-1:0]   gsel;
    logic                gok;

    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [PROD_W-1:0]   prod;
    logic [ACC_W-1:0]    fsum;

    logic [COEF_W-1:0]   frem_step;
    logic [FV_W-1:0]     fq_step;

    logic                empty;
    logic [FV_W-1:0]     lo;
    logic [FV_W-1:0]     hi;
    logic [FV_W-1:0]     yc;
    logic [FV_W-1:0]     d_val;
    logic [FV_W-1:0]     toff_val;
    logic                adiff_neg;
    logic [DEG_W-1:0]    adiff_mag;

    logic [DIVS_W:0]     arem_sh;
    logic [DIVS_W:0]     arem_sub;
    logic                arem_ge;

    // load-time coefficient fixups and gauge select
    assign t_eff = (time_const == '0) ? COEF_W'(1) : time_const;
    assign w_eff = (lag_weight > t_eff) ? t_eff : lag_weight;
    assign gsel  = GIDX_W'(32'(gauge_index));
    assign gok   = (32'(gauge_index) < 32'(NUM_GAUGES));

    // range prep from the fresh filter output
    assign empty    = (rng_reg.val_top <= rng_reg.val_base);
    assign lo       = {rng_reg.val_base, FRAC_W'(0)};
    assign hi       = {rng_reg.val_top, FRAC_W'(0)};
    assign yc       = (fq_reg < lo) ? lo : ((fq_reg > hi) ? hi : fq_reg);
    assign d_val    = empty ? FV_W'(1) : (hi - lo);
    assign toff_val = empty ? '0 : (yc - lo);

    assign adiff_neg = (rng_reg.deg_end < rng_reg.deg_start);
    assign adiff_mag = adiff_neg ? (rng_reg.deg_start - rng_reg.deg_end)
                                 : (rng_reg.deg_end - rng_reg.deg_start);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_MUL_A:
            begin
                mul_a = {x_reg, FRAC_W'(0)};
                mul_b = MUL_B_W'(t_reg - w_reg);
            end
            OP_MUL_B:
            begin
                mul_a = yprev_reg;
                mul_b = MUL_B_W'(w_reg);
            end
            OP_MUL_C:
            begin
                mul_a = d_reg;
                mul_b = MUL_B_W'(rng_reg.deg_start);
            end
            OP_MUL_D:
            begin
                mul_a = toff_reg;
                mul_b = MUL_B_W'(adiff_mag);
            end
            OP_MUL_E:
            begin
                mul_a = MUL_A_W'(n_reg[NUM_LO_W-1:0]);
                mul_b = RAD_NUM;
            end
            OP_MUL_F:
            begin
                mul_a = MUL_A_W'(n_reg[NUM_W-1:NUM_LO_W]);
                mul_b = RAD_NUM;
            end
            OP_MUL_G:
            begin
                mul_a = d_reg;
                mul_b = MUL_B_W'(RAD_DEN);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign fsum = acc_reg + prod[ACC_W-1:0];

    // filter divide, restoring, FDIV_BITS quotient bits per cycle
    always_comb
    begin
        logic [COEF_W:0] r9;
        frem_step = frem_reg;
        fq_step   = fq_reg;
        for (int k = 0; k < FDIV_BITS; k++)
        begin
            r9      = {frem_step, fq_step[FV_W-1]};
            fq_step = {fq_step[FV_W-2:0], 1'b0};
            if (r9 >= {1'b0, t_reg})
            begin
                r9         = r9 - {1'b0, t_reg};
                fq_step[0] = 1'b1;
            end
            frem_step = r9[COEF_W-1:0];
        end
    end

    // angle divide, one quotient bit per cycle
    assign arem_sh  = {arem_reg, aq_reg[QUO_W-1]};
    assign arem_ge  = (arem_sh >= {1'b0, b_reg});
    assign arem_sub = arem_sh - {1'b0, b_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            idx_reg   <= gauge_index;
            ok_reg    <= gok;
            sel_reg   <= gsel;
            x_reg     <= sample;
            t_reg     <= t_eff;
            w_reg     <= w_eff;
            yprev_reg <= fv_reg[gsel];
            rng_reg   <= gauge_range[gauge_index];
        end
        unique case (cmd.op)
            OP_MUL_A:
            begin
                acc_reg <= prod[ACC_W-1:0];
            end
            OP_MUL_B:
            begin
                // quotient is below 2^24, so the top byte is already below T
                frem_reg <= fsum[ACC_W-1:FV_W];
                fq_reg   <= fsum[FV_W-1:0];
            end
            OP_FDIV:
            begin
                frem_reg <= frem_step;
                fq_reg   <= fq_step;
            end
            OP_PREP:
            begin
                d_reg    <= d_val;
                toff_reg <= toff_val;
            end
            OP_MUL_C:
            begin
                n_reg <= prod[NUM_W-1:0];
            end
            OP_MUL_D:
            begin
                // descending range never drives the numerator below zero
                if (adiff_neg)
                    n_reg <= n_reg - prod[NUM_W-1:0];
                else
                    n_reg <= n_reg + prod[NUM_W-1:0];
            end
            OP_MUL_E:
            begin
                a_reg <= DIVD_W'(prod[NUM_LO_W+RAD_NUM_W-1:0]);
            end
            OP_MUL_F:
            begin
                a_reg <= a_reg + {prod[NUM_HI_W+RAD_NUM_W-1:0], NUM_LO_W'(0)};
            end
            OP_MUL_G:
            begin
                // quotient fits QUO_W bits, so the top part starts below the divisor
                b_reg    <= prod[DIVS_W-1:0];
                arem_reg <= DIVS_W'(a_reg[DIVD_W-1:QUO_W]);
                aq_reg   <= a_reg[QUO_W-1:0];
            end
            OP_ADIV:
            begin
                arem_reg <= arem_ge ? arem_sub[DIVS_W-1:0] : arem_sh[DIVS_W-1:0];
                aq_reg   <= {aq_reg[QUO_W-2:0], arem_ge};
            end
            default:
            begin
            end
        endcase
        if (cmd.out_load)
        begin
            gauge_id_reg <= idx_reg;
            if (!ok_reg)
                angle_reg <= '0;
            else if (aq_reg[QUO_W-1])
                angle_reg <= '1;
            else
                angle_reg <= aq_reg[ANGLE_W-1:0];
        end
    end

    // filter state, cleared at reset, written once the divide is done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < NUM_GAUGES; g++)
                fv_reg[g] <= '0;
        end
        else if ((cmd.op == OP_PREP) && ok_reg)
        begin
            fv_reg[sel_reg] <= fq_reg;
        end
    end

    assign gauge_id     = gauge_id_reg;
    assign needle_angle = angle_reg;

endmodule

`default_nettype wire

/* rtl/core/gauge_needle_filter_and_angle_map.sv */
// ----------------------------------------------------------------------------
// gauge_needle_filter_and_angle_map
// Per-gauge first-order low-pass on raw samples, clamped to the gauge's value
// range and mapped linearly onto its angle range in Q3.13 radians.
// ----------------------------------------------------------------------------
// One item is worked on at a time. An accepted item has its result loaded
// into the output register when the angle divide is done; only then is the
// next item taken, and that hand-off waits while the output is full and
// stalled. The work goes through the two shift-subtract dividers (24-bit
// filter quotient at two bits a cycle, 17-bit angle quotient at one bit a
// cycle) and the single 24x29 multiplier that serves the seven products in
// turn. A finished result may wait in the output register while the block
// already accepts and processes the next item. Configuration registers are
// written through cfg_we, cfg_index and cfg_data; the user must write them
// only while no item is in flight, as the block itself does not enforce it.
`default_nettype none

`include "assert_macros.svh"

module gauge_needle_filter_and_angle_map
    import gnf_pkg::*;
#(
    parameter int NUM_GAUGES = NUM_GAUGES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [IDX_W-1:0]      gauge_index,
    input  wire logic [SAMPLE_W-1:0]   sample,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [IDX_W-1:0]           gauge_id,
    output logic [ANGLE_W-1:0]         needle_angle
);

    logic [COEF_W-1:0] time_const_reg;
    logic [COEF_W-1:0] lag_weight_reg;
    range_t            range_reg [NUM_RANGES];
    dp_cmd_t           cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_const_reg <= TIME_CONST_RESET;
            lag_weight_reg <= LAG_WEIGHT_RESET;
            for (int r = 0; r < NUM_RANGES; r++)
                range_reg[r] <= RANGE_RESET[r];
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TIME_CONST: time_const_reg <= cfg_data[COEF_W-1:0];
                REG_LAG_WEIGHT: lag_weight_reg <= cfg_data[COEF_W-1:0];
                REG_RANGE0:     range_reg[0]   <= range_t'(cfg_data);
                REG_RANGE1:     range_reg[1]   <= range_t'(cfg_data);
                REG_RANGE2:     range_reg[2]   <= range_t'(cfg_data);
                REG_RANGE3:     range_reg[3]   <= range_t'(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    gnf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    gnf_dp #(
        .NUM_GAUGES (NUM_GAUGES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .time_const   (time_const_reg),
        .lag_weight   (lag_weight_reg),
        .gauge_range  (range_reg),
        .gauge_index  (gauge_index),
        .sample       (sample),
        .gauge_id     (gauge_id),
        .needle_angle (needle_angle)
    );

    `ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "no busy after accept")
    `ASSERT_IMP(a_result_from_busy, $rose(out_valid), $past(in_stall), "result without item")
    `ASSERT_IMP(a_bad_gauge_zero, out_valid && (32'(gauge_id) >= 32'(NUM_GAUGES)), needle_angle == '0, "bad gauge angle")

endmodule

`default_nettype wire

/* bench/gnf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnf_checker
// Watches the register port and both item channels of the gauge needle
// block, keeps its own copy of the filter levels and ranges, predicts the
// needle angle of every accepted sample and compares it with the result.
// ----------------------------------------------------------------------------
module gnf_checker
    import gnf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [IDX_W-1:0]      gauge_index,
    input  logic [SAMPLE_W-1:0]   sample,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [IDX_W-1:0]      gauge_id,
    input  logic [ANGLE_W-1:0]    needle_angle,
    output int                    mismatches,
    output int                    outstanding,
    output int                    needles_checked
);

    // degrees to Q3.13 radians
    localparam longint DEG_Q13_NUM = 502654816;
    localparam longint DEG_Q13_DEN = 3515625;

    typedef struct packed {
        logic [IDX_W-1:0]   gauge;
        logic [ANGLE_W-1:0] angle;
    } needle_t;

    needle_t           expected_needles [$];
    logic [COEF_W-1:0] time_const;
    logic [COEF_W-1:0] lag_weight;
    range_t            ranges [NUM_RANGES];
    logic [FV_W-1:0]   levels [NUM_GAUGES_DEF];

    function automatic logic [ANGLE_W-1:0] angle_q13(logic [FV_W-1:0] level_now, range_t r);
        longint lo, hi, yc, span, num, quo;
        if (r.val_top <= r.val_base)
        begin
            num  = longint'(r.deg_start);
            span = 1;
        end
        else
        begin
            lo = longint'(r.val_base) * 256;
            hi = longint'(r.val_top) * 256;
            yc = longint'(level_now);
            if (yc < lo)
                yc = lo;
            if (yc > hi)
                yc = hi;
            span = hi - lo;
            num  = longint'(r.deg_start) * span
                 + (yc - lo) * (longint'(r.deg_end) - longint'(r.deg_start));
            if (num < 0)
                num = 0;
        end
        quo = (num * DEG_Q13_NUM) / (span * DEG_Q13_DEN);
        return (quo > 65535) ? 16'hFFFF : quo[ANGLE_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        needle_t got;
        needle_t want;
        longint  x, t_eff, w_eff, y;
        if (!rst_n)
        begin
            time_const = 8'd10;
            lag_weight = 8'd8;
            ranges[0]  = range_t'(50'd199071898009600);
            ranges[1]  = range_t'(50'd436570540670976);
            ranges[2]  = range_t'(50'd436570540670976);
            ranges[3]  = range_t'(50'd199072029081600);
            for (int i = 0; i < NUM_GAUGES_DEF; i++)
                levels[i] = '0;
            expected_needles.delete();
            mismatches      = 0;
            needles_checked = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_TIME_CONST: time_const = cfg_data[COEF_W-1:0];
                    REG_LAG_WEIGHT: lag_weight = cfg_data[COEF_W-1:0];
                    REG_RANGE0, REG_RANGE1, REG_RANGE2, REG_RANGE3:
                        ranges[cfg_index - REG_RANGE0] = range_t'(cfg_data);
                    default: ;
                endcase
            end

            // results first: an item taken at this edge cannot already be out
            if (out_valid && !out_stall)
            begin
                got = '{gauge_id, needle_angle};
                if (expected_needles.size() == 0)
                begin
                    $error("needle result with none expected: gauge_id %0d needle_angle %0d",
                           gauge_id, needle_angle);
                    mismatches++;
                end
                else
                begin
                    want = expected_needles.pop_front();
                    if (got.gauge !== want.gauge)
                    begin
                        $error("gauge_id: expected %0d, got %0d", want.gauge, got.gauge);
                        mismatches++;
                    end
                    if (got.angle !== want.angle)
                    begin
                        $error("needle_angle: expected %0d, got %0d", want.angle, got.angle);
                        mismatches++;
                    end
                end
                needles_checked++;
            end

            if (in_valid && !in_stall)
            begin
                want.gauge = gauge_index;
                if (gauge_index >= NUM_GAUGES_DEF)
                    want.angle = '0;
                else
                begin
                    x     = longint'(sample) * 256;
                    t_eff = (time_const == 0) ? 1 : longint'(time_const);
                    w_eff = (longint'(lag_weight) > t_eff) ? t_eff : longint'(lag_weight);
                    y     = (x * (t_eff - w_eff) + w_eff * longint'(levels[gauge_index])) / t_eff;
                    levels[gauge_index] = y[FV_W-1:0];
                    want.angle = angle_q13(levels[gauge_index], ranges[gauge_index]);
                end
                expected_needles.push_back(want);
            end
        end
        outstanding = expected_needles.size();
    end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives gauge samples into the needle filter and angle map under changing
// filter and range settings and idle patterns, with a checker alongside.
// ----------------------------------------------------------------------------
module tb;
    import gnf_pkg::*;

    localparam int LIMIT_CYCLES  = 1000000;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 128;
    localparam int TAIL_CYCLES   = 64;

    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic [IDX_W-1:0]      gauge_index = '0;
    logic [SAMPLE_W-1:0]   sample      = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic [IDX_W-1:0]      gauge_id;
    logic [ANGLE_W-1:0]    needle_angle;

    int     mismatches;
    int     outstanding;
    int     needles_checked;
    int     send_idle_pct = 0;
    int     stall_pct     = 0;
    bit     hold_req      = 1'b0;
    int     samples_sent  = 0;
    int     settings_used = 0;
    range_t cur_range [NUM_RANGES];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    gauge_needle_filter_and_angle_map u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .gauge_index  (gauge_index),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .gauge_id     (gauge_id),
        .needle_angle (needle_angle)
    );

    gnf_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .gauge_index     (gauge_index),
        .sample          (sample),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .gauge_id        (gauge_id),
        .needle_angle    (needle_angle),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .needles_checked (needles_checked)
    );

    // output side: random stalls, or one long hold-off on request
    initial
    begin : receiver
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $error("timed out after %0d cycles, %0d results outstanding", cycles, outstanding);
        $display("FAIL");
        $finish;
    end

    task automatic send_sample(logic [IDX_W-1:0] g, logic [SAMPLE_W-1:0] s);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        gauge_index <= g;
        sample      <= s;
        samples_sent++;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // block is idle once every sent item has its result
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // upper data bits are junk on purpose, only [7:0] counts
    task automatic set_filter(int tc, int lw);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'({$urandom(), $urandom()});
        d[COEF_W-1:0] = tc[COEF_W-1:0];
        write_reg(REG_TIME_CONST, d);
        d = CFG_DATA_W'({$urandom(), $urandom()});
        d[COEF_W-1:0] = lw[COEF_W-1:0];
        write_reg(REG_LAG_WEIGHT, d);
        settings_used++;
    endtask

    task automatic set_range(int g, int vmin, int vmax, int amin, int amax);
        range_t r;
        r.val_base  = vmin[SAMPLE_W-1:0];
        r.val_top   = vmax[SAMPLE_W-1:0];
        r.deg_start = amin[DEG_W-1:0];
        r.deg_end   = amax[DEG_W-1:0];
        cur_range[g] = r;
        write_reg(cfg_reg_t'(REG_RANGE0 + g), r);
    endtask

    task automatic random_setting();
        int pick, tc, t_eff, lw, lo, hi, a0, a1;
        pick = $urandom_range(99);
        if (pick < 10)
            tc = 0;
        else if (pick < 20)
            tc = 255;
        else if (pick < 25)
            tc = 1;
        else
            tc = $urandom_range(2, 254);
        t_eff = (tc == 0) ? 1 : tc;
        pick = $urandom_range(99);
        if (pick < 10)
            lw = 0;
        else if (pick < 20)
            lw = $urandom_range(t_eff, 255);
        else
            lw = $urandom_range(0, t_eff - 1);
        set_filter(tc, lw);
        for (int g = 0; g < NUM_RANGES; g++)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                lo = $urandom_range(0, 65535);
                hi = $urandom_range(0, lo);
            end
            else if (pick < 20)
            begin
                lo = 0;
                hi = 65535;
            end
            else
            begin
                a0 = $urandom_range(0, 65535);
                a1 = $urandom_range(0, 65535);
                lo = (a0 < a1) ? a0 : a1;
                hi = (a0 < a1) ? a1 : a0;
            end
            pick = $urandom_range(99);
            if (pick < 15)
            begin
                a0 = $urandom_range(0, 511);
                a1 = $urandom_range(0, 511);
            end
            else if (pick < 25)
            begin
                a0 = $urandom_range(0, 100);
                a1 = 511;
            end
            else
            begin
                a0 = $urandom_range(0, 360);
                a1 = $urandom_range(0, 360);
            end
            set_range(g, lo, hi, a0, a1);
        end
    endtask

    // mostly inside the gauge's range, some at its edges or at 0 and all-ones, the rest anywhere
    function automatic logic [SAMPLE_W-1:0] pick_sample(int g);
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            return SAMPLE_W'($urandom_range(cur_range[g].val_base, cur_range[g].val_top));
        else if (pick < 70)
        begin
            case ($urandom_range(3))
                0: return '0;
                1: return '1;
                2: return cur_range[g].val_base;
                default: return cur_range[g].val_top;
            endcase
        end
        return SAMPLE_W'($urandom_range(0, 65535));
    endfunction

    initial
    begin : stimulus
        int                  count, run;
        logic [IDX_W-1:0]    g;
        logic [SAMPLE_W-1:0] target;

        cur_range[0] = range_t'(50'd199071898009600);
        cur_range[1] = range_t'(50'd436570540670976);
        cur_range[2] = range_t'(50'd436570540670976);
        cur_range[3] = range_t'(50'd199072029081600);
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // power-up settings
        send_sample(0, 16'h0000);
        send_sample(1, 16'hFFFF);
        send_sample(2, 16'h5555);
        send_sample(3, 16'hAAAA);
        drain();

        // zero time constant acts as one; no lag, so the level follows the sample
        set_filter(0, 0);
        set_range(0, 1000, 5000, 0, 270);
        set_range(1, 1000, 5000, 270, 0);
        set_range(2, 3000, 3000, 90, 200);
        set_range(3, 0, 65535, 0, 511);
        send_sample(0, 16'd500);
        send_sample(0, 16'd3000);
        send_sample(0, 16'd6000);
        send_sample(1, 16'd500);
        send_sample(1, 16'd3000);
        send_sample(1, 16'hFFFF);
        send_sample(2, 16'd0);
        send_sample(2, 16'hFFFF);
        send_sample(3, 16'hFFFF);
        send_sample(3, 16'd0);
        drain();

        // lag above time constant holds every level; inverted range on gauge 2
        set_filter(5, 200);
        set_range(2, 5000, 1000, 511, 0);
        send_sample(0, 16'd20000);
        send_sample(1, 16'd0);
        send_sample(2, 16'd40000);
        drain();

        // slowest filter, then full hold
        set_filter(255, 254);
        send_sample(3, 16'hFFFF);
        send_sample(3, 16'hFFFF);
        drain();
        set_filter(255, 255);
        send_sample(3, 16'd0);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 81; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 81; end
                default: begin send_idle_pct = 31; stall_pct = 31; end
            endcase
            random_setting();
            // long output hold-off so the block backs up into its input
            if (phase == 4)
                hold_req = 1'b1;
            count = 0;
            while (count < PHASE_ITEMS)
            begin
                g = $urandom_range(0, 3);
                if ($urandom_range(99) < 70)
                begin
                    // steady run on one gauge so the level settles
                    run    = $urandom_range(2, 12);
                    target = pick_sample(g);
                    repeat (run)
                        send_sample(g, target ^ SAMPLE_W'($urandom_range(0, 3)));
                    count += run;
                end
                else
                begin
                    send_sample(g, pick_sample(g));
                    count++;
                end
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (outstanding != 0)
            $error("%0d needle results never arrived", outstanding);
        $display("%0d gauge samples sent under %0d filter settings with varied idling",
                 samples_sent, settings_used);
        $display("%0d needle angles compared, %0d mismatches", needles_checked, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/gnf_pkg.sv
rtl/core/gnf_ctrl.sv
rtl/core/gnf_dp.sv
rtl/core/gauge_needle_filter_and_angle_map.sv
bench/gnf_checker.sv
bench/tb.sv
